/* hw/rtl/mrpt_pkg.sv */
package mrpt_pkg;

    localparam int unsigned XLEN      = 64;
    localparam int unsigned BIT_W     = 6;
    localparam int unsigned TABLE_LEN = 12;
    localparam int unsigned WIDX_W    = 4;

    typedef logic [XLEN-1:0] t_word;

    // multiplier command / status between controller and mod-mul unit
    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
        t_word m;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_word prod;
    } t_mul_rsp;

    function automatic t_word witness_at(input logic [WIDX_W-1:0] idx);
        t_word w;
        case (idx)
            4'd0:    w = 64'd2;
            4'd1:    w = 64'd3;
            4'd2:    w = 64'd5;
            4'd3:    w = 64'd7;
            4'd4:    w = 64'd11;
            4'd5:    w = 64'd13;
            4'd6:    w = 64'd17;
            4'd7:    w = 64'd19;
            4'd8:    w = 64'd23;
            4'd9:    w = 64'd29;
            4'd10:   w = 64'd31;
            4'd11:   w = 64'd37;
            default: w = 64'd0;
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/mrpt_mulmod.sv */
module mrpt_mulmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrpt_pkg::t_mul_req i_req,
    output mrpt_pkg::t_mul_rsp o_rsp
);
    import mrpt_pkg::*;

    logic             r_busy;
    logic [BIT_W-1:0] r_cnt;
    t_word            r_acc;
    t_word            r_a;
    t_word            r_b;
    t_word            r_m;
    logic             r_done;

    t_word w_dbl;
    t_word w_add;
    t_word w_room;

    // one bit of b per cycle: acc = 2*acc (+a) mod m
    always_comb begin
        w_room = r_m - r_acc;
        w_dbl  = (r_acc >= w_room) ? (r_acc - w_room) : (r_acc + r_acc);
        w_room = r_m - r_a;
        w_add  = (w_dbl >= w_room) ? (w_dbl - w_room) : (w_dbl + r_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
                r_acc  <= '0;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_m    <= i_req.m;
            end else if (r_busy) begin
                r_acc <= r_b[XLEN-1] ? w_add : w_dbl;
                r_b   <= {r_b[XLEN-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

    as_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    as_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_acc < r_m)) else $error("product not reduced");
    as_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("start lost");
endmodule

/* hw/rtl/miller_rabin_prime_test_64.sv */
// Values below 4 and even values go straight from the candidate transfer to the output state;
// other multiples of three are rejected after a bit-serial residue pass; otherwise each witness
// costs up to ~128 modular multiplications on the bit-serial mod-mul unit.
// Throughput: one item at a time; the next candidate is taken after the result transfers.
// Reset: synchronous active-low i_rst_n returns control to idle, output invalid.
module miller_rabin_prime_test_64 #(
    parameter int unsigned WITNESS_COUNT = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_candidate,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_prime
);
    import mrpt_pkg::*;

    localparam int unsigned LIMIT = (WITNESS_COUNT > TABLE_LEN) ? TABLE_LEN : WITNESS_COUNT;
    localparam logic [WIDX_W-1:0] LAST_W = WIDX_W'(LIMIT - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD3  = 4'd1;
    localparam logic [3:0] S_SPLIT = 4'd2;
    localparam logic [3:0] S_WIT   = 4'd3;
    localparam logic [3:0] S_PSQ   = 4'd4;
    localparam logic [3:0] S_PMUL  = 4'd5;
    localparam logic [3:0] S_SQ    = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_PCHK  = 4'd8;
    localparam logic [3:0] S_WAIT  = 4'd9;

    logic [3:0]        r_state;
    logic [3:0]        r_ret;
    t_word             r_n;
    t_word             r_d;
    t_word             r_e;
    t_word             r_x;
    t_word             r_base;
    logic [BIT_W-1:0]  r_r;
    logic [BIT_W-1:0]  r_j;
    logic [WIDX_W-1:0] r_wi;
    logic [1:0]        r_rem;
    logic [BIT_W:0]    r_cnt;
    logic              r_res;
    logic              r_ovalid;
    logic              r_start;
    t_word             r_ma;
    t_word             r_mb;

    t_mul_req w_req;
    t_mul_rsp w_rsp;
    t_word    w_nm1;
    t_word    w_wit;

    assign w_nm1 = r_n - 64'd1;
    assign w_wit = witness_at(r_wi);

    assign w_req.start = r_start;
    assign w_req.a     = r_ma;
    assign w_req.b     = r_mb;
    assign w_req.m     = r_n;

    mrpt_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_is_prime = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_start  <= 1'b0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_n   <= i_candidate;
                        r_e   <= i_candidate;
                        r_rem <= 2'd0;
                        r_cnt <= '0;
                        if (i_candidate < 64'd2) begin
                            r_res <= 1'b0; r_state <= S_OUT;
                        end else if (i_candidate < 64'd4) begin
                            r_res <= 1'b1; r_state <= S_OUT;
                        end else if (!i_candidate[0]) begin
                            r_res <= 1'b0; r_state <= S_OUT;
                        end else begin
                            r_state <= S_MOD3;
                        end
                    end
                end
                S_MOD3: begin
                    // residue mod 3, one bit per cycle from the top
                    unique case ({r_rem, r_e[XLEN-1]})
                        3'b000:  r_rem <= 2'd0;
                        3'b001:  r_rem <= 2'd1;
                        3'b010:  r_rem <= 2'd2;
                        3'b011:  r_rem <= 2'd0;
                        3'b100:  r_rem <= 2'd1;
                        3'b101:  r_rem <= 2'd2;
                        default: r_rem <= 2'd0;
                    endcase
                    r_e   <= {r_e[XLEN-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 7'd63) begin
                        r_d <= w_nm1;
                        r_r <= '0;
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    if (r_rem == 2'd0) begin
                        r_res <= 1'b0; r_state <= S_OUT;
                    end else if (!r_d[0]) begin
                        r_d <= {1'b0, r_d[XLEN-1:1]};
                        r_r <= r_r + 1'b1;
                    end else begin
                        r_wi    <= '0;
                        r_res   <= 1'b1;
                        r_state <= S_WIT;
                    end
                end
                S_WIT: begin
                    if (w_wit >= r_n) begin
                        if (r_wi == LAST_W) r_state <= S_OUT;
                        else r_wi <= r_wi + 1'b1;
                    end else begin
                        r_x     <= 64'd1;
                        r_base  <= w_wit;
                        r_e     <= r_d;
                        r_state <= S_PCHK;
                    end
                end
                S_PCHK: begin
                    // right-to-left square and multiply over the exponent
                    if (r_e == '0) begin
                        if (r_x == 64'd1 || r_x == w_nm1) begin
                            if (r_wi == LAST_W) r_state <= S_OUT;
                            else begin r_wi <= r_wi + 1'b1; r_state <= S_WIT; end
                        end else begin
                            r_j <= 6'd1; r_state <= S_SQ;
                        end
                    end else if (r_e[0]) begin
                        r_ma <= r_x; r_mb <= r_base; r_start <= 1'b1;
                        r_ret <= S_PMUL; r_state <= S_WAIT;
                    end else begin
                        r_ma <= r_base; r_mb <= r_base; r_start <= 1'b1;
                        r_ret <= S_PSQ; r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_rsp.done) r_state <= r_ret;
                end
                S_PMUL: begin
                    r_x  <= w_rsp.prod;
                    r_ma <= r_base; r_mb <= r_base; r_start <= 1'b1;
                    r_ret <= S_PSQ; r_state <= S_WAIT;
                end
                S_PSQ: begin
                    r_base  <= w_rsp.prod;
                    r_e     <= {1'b0, r_e[XLEN-1:1]};
                    r_state <= S_PCHK;
                end
                S_SQ: begin
                    if (r_j >= r_r) begin
                        r_res <= 1'b0; r_state <= S_OUT;
                    end else if (r_ret == S_SQ) begin
                        // squaring finished: test against n-1
                        r_ret <= S_PCHK;
                        r_x   <= w_rsp.prod;
                        r_j   <= r_j + 1'b1;
                        if (w_rsp.prod == w_nm1) begin
                            if (r_wi == LAST_W) r_state <= S_OUT;
                            else begin r_wi <= r_wi + 1'b1; r_state <= S_WIT; end
                        end
                    end else begin
                        r_ma <= r_x; r_mb <= r_x; r_start <= 1'b1;
                        r_ret <= S_SQ; r_state <= S_WAIT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) r_ovalid <= 1'b1;
                    else if (i_ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    as_out_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == S_OUT)) else $error("result outside output state");
    as_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    as_wait_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == S_WAIT)) else $error("multiply started outside wait");
endmodule

/* test/tb_miller_rabin_prime_test_64.sv */
`timescale 1ns / 100ps

module tb_miller_rabin_prime_test_64;

    import mrpt_pkg::*;

    localparam int unsigned N_WITNESS   = 12;
    localparam int unsigned N_RANDOM    = 90;
    localparam int unsigned STALL_LIMIT = 400000;
    localparam int unsigned DRAIN_WAIT  = 300;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_word i_candidate;
    logic  o_valid;
    logic  i_ready;
    logic  o_is_prime;

    miller_rabin_prime_test_64 #(
        .WITNESS_COUNT(N_WITNESS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_candidate(i_candidate),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_is_prime (o_is_prime)
    );

    t_word       cand_q[$];
    logic        verdict_q[$];
    int unsigned n_sent;
    int unsigned n_total;
    int unsigned pause_at;
    int unsigned n_checked;
    int unsigned n_primes;
    int unsigned n_errors;
    int unsigned idle_cycles;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned cyc;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // (a * b) mod m, exact through a double-width product
    function automatic t_word mod_mul(input t_word a, input t_word b, input t_word m);
        logic [2*XLEN-1:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return t_word'(prod % {64'd0, m});
    endfunction

    function automatic t_word mod_pow(input t_word base, input t_word ex, input t_word m);
        t_word acc;
        t_word b;
        acc = 64'd1 % m;
        b   = base % m;
        while (ex != 0) begin
            if (ex[0]) acc = mod_mul(acc, b, m);
            b  = mod_mul(b, b, m);
            ex = ex >> 1;
        end
        return acc;
    endfunction

    function automatic logic primality(input t_word n);
        t_word wit[12];
        t_word d;
        t_word nm1;
        t_word x;
        int    r;
        int    lim;
        bit    hit;
        wit = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
                64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37};
        if (n < 2) return 1'b0;
        if (n < 4) return 1'b1;
        if (!n[0] || (n % 3) == 0) return 1'b0;
        nm1 = n - 1;
        d   = nm1;
        r   = 0;
        while (!d[0] && r < 63) begin
            d = d >> 1;
            r++;
        end
        lim = (N_WITNESS > 12) ? 12 : N_WITNESS;
        for (int i = 0; i < lim; i++) begin
            if (wit[i] >= n) continue;
            x = mod_pow(wit[i], d, n);
            if (x == 1 || x == nm1) continue;
            hit = 1'b0;
            for (int j = 1; j < r; j++) begin
                x = mod_mul(x, x, n);
                if (x == nm1) begin
                    hit = 1'b1;
                    break;
                end
            end
            if (!hit) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_word rand_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        n_errors++;
    endtask

    // driver: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        bit    send;
        bit    gap_now;
        t_word c;
        send    = 1'b0;
        gap_now = 1'b0;
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_candidate <= '0;
            burst_left  <= 0;
            gap_left    <= 0;
            n_sent      <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                verdict_q.push_back(primality(i_candidate));
                n_sent <= n_sent + 1;
            end
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                gap_now  = 1'b1;
            end
            // hold off once until every outstanding result has come back
            if (!gap_now && cand_q.size() != 0 &&
                !((n_sent + i_valid) == pause_at && verdict_q.size() != 0)) begin
                send = 1'b1;
                c    = cand_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 6);
                    gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
            i_valid <= send;
            if (send) i_candidate <= c;
        end
    end

    // receiver: periodic stall windows plus scattered single-cycle stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            cyc     <= 0;
        end else begin
            cyc <= cyc + 1;
            if ((cyc % 97) < 20)
                i_ready <= 1'b0;
            else if ((cyc % 512) >= 300)
                i_ready <= 1'b1;
            else
                i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("result %0b with none expected", o_is_prime));
            end else begin
                want = verdict_q.pop_front();
                if (o_is_prime !== want)
                    report_mismatch($sformatf("is_prime %0b, want %0b", o_is_prime, want));
                if (want) n_primes++;
            end
            n_checked++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("miller_rabin_prime_test_64: mismatch");
                $finish;
            end
        end
    end

    initial begin
        t_word c;
        int    pick;
        int    w;
        i_rst_n     = 1'b0;
        n_checked   = 0;
        n_primes    = 0;
        n_errors    = 0;

        // small edges, witness skipping, pseudoprimes, and 64-bit extremes
        cand_q = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd25,
                   64'd37, 64'd41, 64'd561, 64'd2047, 64'd7919, 64'd65537,
                   64'd1373653, 64'd3215031751, 64'd4294967291,
                   64'd2305843009213693951, 64'd3825123056546413051,
                   64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
                   64'hAAAA_AAAA_AAAA_AAAB};
        pause_at = cand_q.size();

        for (int k = 0; k < N_RANDOM; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // odd, not a multiple of three: reaches the witness loop unless it is 1
                w = $urandom_range(3, 20);
                c = rand_word() & ((64'd1 << w) - 1);
                c[0] = 1'b1;
                if (c % 3 == 0) c = c + 2;
            end else if (pick < 80) begin
                c = rand_word();
                c[0] = 1'b1;
                if (c % 3 == 0) c = c - 2;
            end else if (pick < 90) begin
                c = rand_word();
            end else begin
                c = 64'($urandom_range(0, 40));
            end
            cand_q.push_back(c);
        end
        n_total = cand_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent < n_total || verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));

        $display("checked %0d candidates (%0d prime), including 64-bit extremes,",
                 n_checked, n_primes);
        $display("strong pseudoprimes and small values that skip witnesses");
        if (n_errors == 0) begin
            $display("miller_rabin_prime_test_64: match");
        end else begin
            $display("miller_rabin_prime_test_64: mismatch");
        end
        $finish;
    end

endmodule
